[rtl/core/wmcd_pkg.sv]
// Package with the shared types and constants of the C-mode deframer.
`default_nettype none

package wmcd_pkg;

  localparam logic [7:0] PRE_C = 8'h54;
  localparam logic [7:0] PRE_A = 8'hCD;
  localparam logic [7:0] PRE_B = 8'h3D;

  localparam logic [4:0] FIRST_BLOCK_DATA = 5'd10;
  localparam logic [4:0] NEXT_BLOCK_DATA  = 5'd16;
  localparam logic [4:0] CRC_LEN          = 5'd2;
  localparam logic [9:0] PREFIX_LEN       = 10'd2;
  localparam logic [9:0] COUNT_MAX        = 10'd1023;

  localparam logic [7:0] MIN_PACKET_RST = 8'd16;
  localparam logic [8:0] MIN_FRAME_RST  = 9'd12;

  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PACKET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAME  = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_TOO_SHORT   = 3'd1,
    ST_UNKNOWN_PRE = 3'd2,
    ST_L_INVALID   = 3'd3,
    ST_TRUNCATED   = 3'd4,
    ST_STRIP_FAIL  = 3'd5,
    ST_NOT_C_MODE  = 3'd6
  } status_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       is_status;
    status_e    status_code;
    logic       format_b;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/wmbus_c_mode_deframer.sv]
// Wireless M-Bus C-mode deframer for frame formats A and B.
//
// Raw packet bytes enter on the s_axis channel, one byte per request, with
// s_axis_tlast on the final byte. The prefix 0x54 and the format byte are
// dropped, and the L-field plus L further link-layer bytes leave on the
// m_axis channel with the format A CRC bytes removed. The byte marked last
// produces an extra status request, flagged by m_axis_tuser and m_axis_tlast.
// Each accepted byte is parsed in the cycle it arrives and its results are
// written into a four-entry result queue, from which m_axis is driven in
// order. One byte is taken every cycle while the queue has room for two
// results; the status request adds one extra result per packet. When the
// receiver stalls the queue fills and s_axis_tready drops until two entries
// are free again. Reset empties the queue, clears the parser state and loads
// the threshold registers with their defaults (16 raw bytes, L+1 of 12). The
// threshold registers are written through the cfg port; the user must do so
// only while no packet is in progress, as the block does not enforce it.
`default_nettype none

module wmbus_c_mode_deframer (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output      logic                           s_axis_tready,
  input  wire logic [7:0]                     s_axis_tdata,  // in_byte[7:0]
  input  wire logic                           s_axis_tlast,
  output      logic                           m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // frame_byte[7:0], status_code[10:8], format_b[11], zero[15:12]
  output      logic [15:0]                    m_axis_tdata,
  output      logic                           m_axis_tuser,  // is_status[0]
  output      logic                           m_axis_tlast,
  input  wire logic                           cfg_we_i,
  input  wire logic [wmcd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [wmcd_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import wmcd_pkg::*;

  logic [7:0] min_packet_q;
  logic [8:0] min_frame_q;

  logic [9:0] byte_count_q, byte_count_d;
  logic [7:0] length_q, length_d;
  logic       mode_c_q, mode_c_d;
  logic       fmt_b_q, fmt_b_d;
  logic       pre_unk_q, pre_unk_d;
  logic [8:0] emitted_q, emitted_d;
  logic [4:0] blk_off_q, blk_off_d;
  logic       first_blk_q, first_blk_d;

  result_t             queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   count_q;

  logic       accept, pop;
  logic       push_data, push_status;
  logic [8:0] want;
  logic       want_ok;
  logic [4:0] lim, off_inc;
  logic       is_data;
  status_e    code;
  result_t    data_res, status_res;
  logic [1:0] push_n;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign pop    = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_packet_q <= MIN_PACKET_RST;
      min_frame_q  <= MIN_FRAME_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_PACKET: min_packet_q <= cfg_data_i[7:0];
        CFG_MIN_FRAME:  min_frame_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    byte_count_d = byte_count_q;
    length_d     = length_q;
    mode_c_d     = mode_c_q;
    fmt_b_d      = fmt_b_q;
    pre_unk_d    = pre_unk_q;
    emitted_d    = emitted_q;
    blk_off_d    = blk_off_q;
    first_blk_d  = first_blk_q;
    push_data    = 1'b0;
    lim          = first_blk_q ? FIRST_BLOCK_DATA : NEXT_BLOCK_DATA;
    off_inc      = blk_off_q + 5'd1;
    is_data      = 1'b1;

    if (byte_count_q == 10'd0) begin
      mode_c_d = (s_axis_tdata == PRE_C);
    end else if (byte_count_q == 10'd1) begin
      if (mode_c_q) begin
        if (s_axis_tdata == PRE_A) begin
          fmt_b_d = 1'b0;
        end else if (s_axis_tdata == PRE_B) begin
          fmt_b_d = 1'b1;
        end else begin
          pre_unk_d = 1'b1;
        end
      end
    end else if (mode_c_q && !pre_unk_q) begin
      if (byte_count_q == PREFIX_LEN) begin
        length_d = s_axis_tdata;
      end
      if ({1'b0, length_d} + 9'd1 >= min_frame_q) begin
        if (!fmt_b_q) begin
          is_data = blk_off_q < lim;
          if (off_inc >= lim + CRC_LEN) begin
            blk_off_d   = 5'd0;
            first_blk_d = 1'b0;
          end else begin
            blk_off_d = off_inc;
          end
        end
        if (is_data && emitted_q < {1'b0, length_d} + 9'd1) begin
          push_data = 1'b1;
          emitted_d = emitted_q + 9'd1;
        end
      end
    end

    if (byte_count_q != COUNT_MAX) begin
      byte_count_d = byte_count_q + 10'd1;
    end

    want    = {1'b0, length_d} + 9'd1;
    want_ok = want >= min_frame_q;

    if (!mode_c_d) begin
      code = ST_NOT_C_MODE;
    end else if (byte_count_d < {2'b00, min_packet_q} || byte_count_d < PREFIX_LEN + 10'd1) begin
      code = ST_TOO_SHORT;
    end else if (pre_unk_d) begin
      code = ST_UNKNOWN_PRE;
    end else if (!want_ok) begin
      code = ST_L_INVALID;
    end else if (byte_count_d - PREFIX_LEN < {1'b0, want}) begin
      code = ST_TRUNCATED;
    end else if (!fmt_b_d && emitted_d < want) begin
      code = ST_STRIP_FAIL;
    end else begin
      code = ST_OK;
    end

    push_status = s_axis_tlast;

    data_res.frame_byte    = s_axis_tdata;
    data_res.is_status     = 1'b0;
    data_res.status_code   = ST_OK;
    data_res.format_b      = fmt_b_d;
    status_res.frame_byte  = 8'd0;
    status_res.is_status   = 1'b1;
    status_res.status_code = code;
    status_res.format_b    = fmt_b_d;

    if (s_axis_tlast) begin
      byte_count_d = 10'd0;
      length_d     = 8'd0;
      mode_c_d     = 1'b0;
      fmt_b_d      = 1'b0;
      pre_unk_d    = 1'b0;
      emitted_d    = 9'd0;
      blk_off_d    = 5'd0;
      first_blk_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= 10'd0;
      length_q     <= 8'd0;
      mode_c_q     <= 1'b0;
      fmt_b_q      <= 1'b0;
      pre_unk_q    <= 1'b0;
      emitted_q    <= 9'd0;
      blk_off_q    <= 5'd0;
      first_blk_q  <= 1'b1;
    end else if (accept) begin
      byte_count_q <= byte_count_d;
      length_q     <= length_d;
      mode_c_q     <= mode_c_d;
      fmt_b_q      <= fmt_b_d;
      pre_unk_q    <= pre_unk_d;
      emitted_q    <= emitted_d;
      blk_off_q    <= blk_off_d;
      first_blk_q  <= first_blk_d;
    end
  end

  // The data result goes first; the status result follows in the next slot.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (push_data) begin
        queue_q[wr_ptr_q] <= data_res;
      end
      if (push_status) begin
        queue_q[push_data ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q] <= status_res;
      end
    end
  end

  assign push_n = accept ? {1'b0, push_data} + {1'b0, push_status} : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPTR_W'(push_n);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      count_q <= count_q + QCNT_W'(push_n) - QCNT_W'(pop);
    end
  end

  assign s_axis_tready = count_q <= QCNT_W'(QUEUE_DEPTH - 2);
  assign m_axis_tvalid = count_q != '0;
  assign m_axis_tdata  = {4'd0, queue_q[rd_ptr_q].format_b,
                          queue_q[rd_ptr_q].status_code, queue_q[rd_ptr_q].frame_byte};
  assign m_axis_tuser  = queue_q[rd_ptr_q].is_status;
  assign m_axis_tlast  = queue_q[rd_ptr_q].is_status;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_axis_tlast |=> byte_count_q == 10'd0 && first_blk_q)
    else $error("parser state not cleared after last byte");

  a_status_pushed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_axis_tlast && count_q == '0 && !push_data |=> m_axis_tvalid && m_axis_tuser)
    else $error("status result missing after last byte");

  a_data_code_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[10:8] == 3'd0)
    else $error("data result carries a status code");

  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emitted_q <= {1'b0, length_q} + 9'd1)
    else $error("more bytes emitted than the L-field allows");

endmodule

`default_nettype wire

[dv/tb_wmbus_c_mode_deframer.sv]
// Self-checking testbench for the C-mode deframer, with its own byte-level parser model.
`timescale 1ns / 100ps

module tb_wmbus_c_mode_deframer;
  import wmcd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int FIRST_BLOCK = 10;
  localparam int NEXT_BLOCK = 16;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } raw_byte_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       is_status;
    status_e    status_code;
    logic       format_b;
    logic       out_last;
  } frame_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  wmbus_c_mode_deframer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  raw_byte_t raw_q[$];
  frame_out_t frame_out_q[$];
  logic [7:0] pkt_buf[$];

  int n_queued = 0;
  int n_offered = 0;
  int n_taken = 0;
  int n_packets = 0;
  int n_data_seen = 0;
  int n_status_seen = 0;
  int n_errors = 0;
  int cycle_cnt = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  // Model of the parser: thresholds and per-packet state.
  logic [7:0] min_pkt = MIN_PACKET_RST;
  logic [8:0] min_frm = MIN_FRAME_RST;
  logic [9:0] pk_count;
  logic [7:0] len_field;
  logic       seen_c;
  logic       fmt_b;
  logic       pre_bad;
  logic [8:0] emitted;
  logic [4:0] blk_off;
  logic       first_blk;

  task automatic clear_parser();
    pk_count = '0;
    len_field = '0;
    seen_c = 1'b0;
    fmt_b = 1'b0;
    pre_bad = 1'b0;
    emitted = '0;
    blk_off = '0;
    first_blk = 1'b1;
  endtask

  task automatic deframe_byte(input logic [7:0] b, input logic last);
    logic [8:0] want;
    logic [4:0] lim;
    bit is_data;
    status_e code;
    frame_out_t r;
    if (pk_count == 0) begin
      seen_c = (b == PRE_C);
    end else if (pk_count == 1) begin
      if (seen_c) begin
        if (b == PRE_A) fmt_b = 1'b0;
        else if (b == PRE_B) fmt_b = 1'b1;
        else pre_bad = 1'b1;
      end
    end else if (seen_c && !pre_bad) begin
      if (pk_count == PREFIX_LEN) len_field = b;
      want = {1'b0, len_field} + 9'd1;
      if (want >= min_frm) begin
        is_data = 1'b1;
        if (!fmt_b) begin
          lim = first_blk ? FIRST_BLOCK_DATA : NEXT_BLOCK_DATA;
          is_data = (blk_off < lim);
          blk_off = blk_off + 5'd1;
          if (blk_off >= lim + CRC_LEN) begin
            blk_off = '0;
            first_blk = 1'b0;
          end
        end
        if (is_data && emitted < want) begin
          r = '{frame_byte: b, is_status: 1'b0, status_code: ST_OK, format_b: fmt_b,
                out_last: 1'b0};
          frame_out_q = {frame_out_q, r};
          emitted = emitted + 9'd1;
        end
      end
    end
    if (pk_count < COUNT_MAX) pk_count = pk_count + 10'd1;
    if (last) begin
      want = {1'b0, len_field} + 9'd1;
      if (!seen_c) code = ST_NOT_C_MODE;
      else if (int'(pk_count) < int'(min_pkt) || pk_count < PREFIX_LEN + 10'd1)
        code = ST_TOO_SHORT;
      else if (pre_bad) code = ST_UNKNOWN_PRE;
      else if (want < min_frm) code = ST_L_INVALID;
      else if (int'(pk_count) - 2 < int'(want)) code = ST_TRUNCATED;
      else if (!fmt_b && emitted < want) code = ST_STRIP_FAIL;
      else code = ST_OK;
      r = '{frame_byte: 8'h00, is_status: 1'b1, status_code: code, format_b: fmt_b,
            out_last: 1'b1};
      frame_out_q = {frame_out_q, r};
      clear_parser();
    end
  endtask

  function automatic int idle_phase();
    return (n_taken < 700) ? 0 : (n_taken < 1400) ? 1 : 2;
  endfunction

  function automatic int send_idle_pct();
    return (idle_phase() == 0) ? 11 : (idle_phase() == 1) ? 52 : 0;
  endfunction

  function automatic int recv_idle_pct();
    return (idle_phase() == 0) ? 52 : (idle_phase() == 1) ? 11 : 0;
  endfunction

  // Request acceptance on the input side feeds the parser model.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      void'(raw_q.pop_front());
      n_taken++;
      deframe_byte(s_axis_tdata, s_axis_tlast);
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && n_taken < n_offered) begin
      // Hold the current request until it is taken.
    end else if (raw_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= raw_q[0].b;
      s_axis_tlast <= raw_q[0].last;
      n_offered++;
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_phase() == 2 && !hold_done && m_axis_tvalid) begin
      // One long stall so that the result queue fills and backpressures the input.
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct());
    end
  end

  always @(posedge clk_i) begin
    frame_out_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (m_axis_tuser) n_status_seen++;
      else n_data_seen++;
      if (frame_out_q.size() == 0) begin
        $error("unexpected result: frame_byte %0h status %0d", m_axis_tdata[7:0],
               m_axis_tdata[10:8]);
        n_errors++;
      end else begin
        exp_r = frame_out_q.pop_front();
        if (m_axis_tdata[7:0] !== exp_r.frame_byte) begin
          $error("frame_byte: expected %0h, got %0h", exp_r.frame_byte, m_axis_tdata[7:0]);
          n_errors++;
        end
        if (m_axis_tuser !== exp_r.is_status) begin
          $error("is_status: expected %0d, got %0d", exp_r.is_status, m_axis_tuser);
          n_errors++;
        end
        if (m_axis_tdata[10:8] !== exp_r.status_code) begin
          $error("status_code: expected %0d, got %0d", exp_r.status_code, m_axis_tdata[10:8]);
          n_errors++;
        end
        if (m_axis_tdata[11] !== exp_r.format_b) begin
          $error("format_b: expected %0d, got %0d", exp_r.format_b, m_axis_tdata[11]);
          n_errors++;
        end
        if (m_axis_tlast !== exp_r.out_last) begin
          $error("out_last: expected %0d, got %0d", exp_r.out_last, m_axis_tlast);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               frame_out_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic flush_packet();
    raw_byte_t item;
    while (pkt_buf.size() != 0) begin
      item.b = pkt_buf.pop_front();
      item.last = (pkt_buf.size() == 0);
      raw_q = {raw_q, item};
      n_queued++;
    end
    n_packets++;
  endtask

  // Builds a C-mode frame, keeping only the first keep bytes when keep is nonzero.
  task automatic queue_frame(input bit as_b, input int l_field, input int keep, input int extra);
    int n_data;
    n_data = l_field + 1;
    pkt_buf = {pkt_buf, PRE_C};
    pkt_buf = {pkt_buf, as_b ? PRE_B : PRE_A};
    for (int i = 0; i < n_data; i++) begin
      pkt_buf = {pkt_buf, (i == 0) ? 8'(l_field) : 8'($urandom)};
      if (!as_b && (i + 1 == FIRST_BLOCK || i + 1 == n_data ||
                    (i + 1 > FIRST_BLOCK && (i + 1 - FIRST_BLOCK) % NEXT_BLOCK == 0))) begin
        pkt_buf = {pkt_buf, 8'($urandom)};
        pkt_buf = {pkt_buf, 8'($urandom)};
      end
    end
    repeat (extra) pkt_buf = {pkt_buf, 8'($urandom)};
    if (keep > 0) while (pkt_buf.size() > keep) void'(pkt_buf.pop_back());
    flush_packet();
  endtask

  task automatic random_packet();
    int kind;
    int lo;
    int hi;
    int l_pick;
    kind = $urandom_range(0, 99);
    lo = int'(min_frm) - 1;
    hi = (lo + 24 > 255) ? 255 : lo + 24;
    l_pick = $urandom_range(lo, hi);
    if (kind < 70) begin
      queue_frame(1'($urandom_range(0, 1)), l_pick, 0,
                  ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
    end else if (kind < 80) begin
      queue_frame(1'($urandom_range(0, 1)), l_pick, $urandom_range(1, l_pick + 6), 0);
    end else if (kind < 88) begin
      if ($urandom_range(0, 1)) pkt_buf = {pkt_buf, 8'($urandom)};
      else pkt_buf = {pkt_buf, PRE_C};
      pkt_buf = {pkt_buf, 8'($urandom)};
      repeat ($urandom_range(0, 18)) pkt_buf = {pkt_buf, 8'($urandom)};
      flush_packet();
    end else if (kind < 94) begin
      queue_frame(1'($urandom_range(0, 1)), $urandom_range(0, lo - 1), 0,
                  $urandom_range(0, 12));
    end else begin
      pkt_buf = {pkt_buf, ($urandom_range(0, 3) != 0) ? PRE_C : 8'($urandom)};
      repeat ($urandom_range(0, 23)) pkt_buf = {pkt_buf, 8'($urandom)};
      flush_packet();
    end
  endtask

  task automatic wait_drained();
    while (raw_q.size() != 0 || frame_out_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limits(input int pkt_min, input int frm_min);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = CFG_MIN_PACKET;
    cfg_data_i = CFG_DATA_W'(pkt_min);
    @(negedge clk_i);
    cfg_idx_i = CFG_MIN_FRAME;
    cfg_data_i = CFG_DATA_W'(frm_min);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    min_pkt = 8'(pkt_min);
    min_frm = 9'(frm_min);
  endtask

  task automatic random_batch(input int budget);
    int start;
    start = n_queued;
    while (n_queued - start < budget) random_packet();
    wait_drained();
  endtask

  initial begin
    clear_parser();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset thresholds: a minimal valid format B frame and a non C-mode byte.
    queue_frame(1'b1, 13, 0, 0);
    pkt_buf = '{8'h00};
    flush_packet();
    wait_drained();

    // Low thresholds, so that every status is reachable with short packets.
    write_limits(0, 2);
    pkt_buf = '{PRE_C};
    flush_packet();
    pkt_buf = '{PRE_C, PRE_A};
    flush_packet();
    pkt_buf = '{PRE_C, 8'h12, 8'h05};
    flush_packet();
    pkt_buf = '{8'hFF, PRE_C, PRE_A};
    flush_packet();
    queue_frame(1'b1, 0, 0, 0);
    queue_frame(1'b1, 3, 4, 0);
    queue_frame(1'b1, 1, 0, 0);
    queue_frame(1'b0, 10, 14, 0);
    queue_frame(1'b0, 1, 0, 1);
    queue_frame(1'b0, 9, 13, 0);
    wait_drained();

    random_batch(120);

    // High thresholds: only the largest L-field is accepted.
    write_limits(255, 256);
    queue_frame(1'b0, 255, 0, 0);
    random_batch(40);

    write_limits($urandom_range(0, 40), $urandom_range(2, 40));
    random_batch(120);

    // Back to the reset values; one overlong packet drives the byte counter into saturation.
    write_limits(MIN_PACKET_RST, MIN_FRAME_RST);
    queue_frame(1'b1, 20, 0, 1005);
    random_batch(100);

    $display("Summary: %0d bytes in %0d packets over four threshold settings,", n_taken,
             n_packets);
    $display("         %0d data bytes and %0d status results checked", n_data_seen,
             n_status_seen);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[wmbus_c_mode_deframer.f]
rtl/core/wmcd_pkg.sv
rtl/core/wmbus_c_mode_deframer.sv
dv/tb_wmbus_c_mode_deframer.sv
